>>> rtl/core/acs_pkg.sv
`default_nettype none

package acs_pkg;

  localparam int unsigned MaxInnerDef  = 4096;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned InnerCfgW = 13;
  localparam int unsigned AxisCfgW  = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INNER_BLOCK_SIZE = 1'b0,
    CFG_AXIS_LENGTH      = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> rtl/core/acs_sat_add.sv
`default_nettype none

// Three-term signed add with clipping to the data range.
module acs_sat_add #(
  parameter int unsigned DATA_WIDTH = acs_pkg::DataWidthDef
) (
  input  wire logic signed [DATA_WIDTH-1:0] a_i,
  input  wire logic signed [DATA_WIDTH-1:0] b_i,
  input  wire logic signed [DATA_WIDTH-1:0] c_i,
  output logic signed [DATA_WIDTH-1:0]      sum_o,
  output logic                              saturated_o
);

  localparam int unsigned ExtW = DATA_WIDTH + 2;

  logic signed [ExtW-1:0] full;
  logic                   in_range;

  assign full = ExtW'(a_i) + ExtW'(b_i) + ExtW'(c_i);
  assign in_range = (full[ExtW-1:DATA_WIDTH-1] == '0) || (full[ExtW-1:DATA_WIDTH-1] == '1);

  always_comb begin
    if (in_range) begin
      sum_o = full[DATA_WIDTH-1:0];
    end else if (full[ExtW-1]) begin
      sum_o = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      sum_o = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
  end

  assign saturated_o = !in_range;

endmodule

`default_nettype wire

>>> rtl/core/axis_cumulative_sum_core.sv
// Running sum along one axis of a tensor streamed one element per word.
// Input channel: value_i, prior_i, tensor_start_i with in_valid_i / in_stall_o.
// Output channel: sum_o, saturated_o with out_valid_o / out_stall_i.
// A word is taken at a clock edge where valid is high and stall is low.
// Config: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (0 = inner block size, 1 = axis length); write only while idle.
// The input word and the line store read are registered into the compute stage
// at input accept; the sum is then registered into the output register.
// Throughput is one word per cycle while the output is not stalled; the line
// store has one read and one write port: it is read at input accept and
// written when the sum moves into the output register, with the result of the
// word just ahead forwarded when both touch one entry.
// Reset clears the counters, the valid flags and sets both config registers
// to 1; line store contents are undefined until written.
// When the receiver stalls, the output register holds its word and the
// compute stage behind it holds; input stall rises only when that stage is
// full and cannot move on.
`default_nettype none

module axis_cumulative_sum_core #(
  parameter int unsigned MAX_INNER  = acs_pkg::MaxInnerDef,
  parameter int unsigned DATA_WIDTH = acs_pkg::DataWidthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic [acs_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [acs_pkg::CfgDataW-1:0]       cfg_data_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic signed [DATA_WIDTH-1:0]       value_i,
  input  wire logic signed [DATA_WIDTH-1:0]       prior_i,
  input  wire logic                               tensor_start_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic signed [DATA_WIDTH-1:0]            sum_o,
  output logic                                    saturated_o
);

  localparam int unsigned IW   = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int unsigned CntW = ((IW + 1) > acs_pkg::InnerCfgW) ? (IW + 1)
                                                                 : acs_pkg::InnerCfgW;
  localparam int unsigned AW   = acs_pkg::AxisCfgW;

  // config registers
  logic [acs_pkg::InnerCfgW-1:0] inner_size_q;
  logic [AW-1:0]                 axis_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_size_q <= acs_pkg::InnerCfgW'(1);
      axis_len_q   <= AW'(1);
    end else if (cfg_we_i) begin
      case (acs_pkg::cfg_idx_e'(cfg_idx_i))
        acs_pkg::CFG_INNER_BLOCK_SIZE: inner_size_q <= cfg_data_i[acs_pkg::InnerCfgW-1:0];
        acs_pkg::CFG_AXIS_LENGTH:      axis_len_q   <= cfg_data_i[AW-1:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] isize;
  logic [AW:0]     alen;

  always_comb begin
    if (inner_size_q == '0) begin
      isize = CntW'(1);
    end else if (CntW'(inner_size_q) > CntW'(MAX_INNER)) begin
      isize = CntW'(MAX_INNER);
    end else begin
      isize = CntW'(inner_size_q);
    end
    alen = (axis_len_q == '0) ? (AW+1)'(1) : {1'b0, axis_len_q};
  end

  // handshake
  logic s1_vld_q, out_vld_q;
  logic out_adv, s1_adv, in_acc;

  assign out_adv    = !out_vld_q || !out_stall_i;
  assign s1_adv     = s1_vld_q && out_adv;
  assign in_stall_o = s1_vld_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // position counters
  logic [IW-1:0] inner_q, inner_d;
  logic [AW-1:0] axis_q, axis_d;
  logic [IW-1:0] pos_cur;
  logic [AW-1:0] ax_cur;
  logic [CntW-1:0] inner_inc;
  logic [AW:0]     axis_inc;

  always_comb begin
    pos_cur   = tensor_start_i ? '0 : inner_q;
    ax_cur    = tensor_start_i ? '0 : axis_q;
    inner_inc = CntW'(pos_cur) + CntW'(1);
    axis_inc  = {1'b0, ax_cur} + (AW+1)'(1);
    inner_d   = inner_q;
    axis_d    = axis_q;
    if (in_acc) begin
      if (inner_inc >= isize) begin
        inner_d = '0;
        axis_d  = (axis_inc >= alen) ? '0 : axis_inc[AW-1:0];
      end else begin
        inner_d = inner_inc[IW-1:0];
        axis_d  = ax_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q   <= '0;
      axis_q    <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      inner_q <= inner_d;
      axis_q  <= axis_d;
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (out_adv) begin
        out_vld_q <= s1_vld_q;
      end
    end
  end

  // compute stage
  logic signed [DATA_WIDTH-1:0] s1_val_q, s1_pri_q, rd_q, fwd_data_q;
  logic                         s1_use_q, fwd_q;
  logic [IW-1:0]                s1_addr_q;
  logic signed [DATA_WIDTH-1:0] line_word, add_term, new_sum;
  logic                         new_sat;

  assign line_word = fwd_q ? fwd_data_q : rd_q;
  assign add_term  = s1_use_q ? line_word : '0;

  acs_sat_add #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sat_add (
    .a_i         (s1_val_q),
    .b_i         (s1_pri_q),
    .c_i         (add_term),
    .sum_o       (new_sum),
    .saturated_o (new_sat)
  );

  // line store, read before write in the same edge
  logic signed [DATA_WIDTH-1:0] line_mem [MAX_INNER];

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      line_mem[s1_addr_q] <= new_sum;
    end
    if (in_acc) begin
      rd_q <= line_mem[pos_cur];
    end
  end

  logic signed [DATA_WIDTH-1:0] sum_q;
  logic                         sat_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_val_q   <= value_i;
      s1_pri_q   <= prior_i;
      s1_use_q   <= (ax_cur != '0);
      s1_addr_q  <= pos_cur;
      fwd_q      <= s1_adv && (s1_addr_q == pos_cur);
      fwd_data_q <= new_sum;
    end
    if (s1_adv) begin
      sum_q <= new_sum;
      sat_q <= new_sat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign sum_o       = sum_q;
  assign saturated_o = sat_q;

endmodule

`default_nettype wire

>>> verif/testbench.sv
`default_nettype none

module testbench;
  import acs_pkg::*;

  localparam int unsigned HoldLen = 300;
  localparam longint SumMax = 64'sd2147483647;
  localparam longint SumMin = -64'sd2147483648;

  class cumsum_scoreboard;
    logic signed [31:0] line_mem [MaxInnerDef];
    bit                 line_valid [MaxInnerDef];
    int unsigned        inner_pos;
    int unsigned        axis_pos;
    logic [12:0]        inner_size;
    logic [15:0]        axis_len;
    logic signed [31:0] expected_sums [$];
    logic               expected_flags [$];
    int unsigned        errors;

    function new();
      inner_pos  = 0;
      axis_pos   = 0;
      inner_size = 13'd1;
      axis_len   = 16'd1;
      errors     = 0;
      foreach (line_valid[i]) line_valid[i] = 1'b0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] d);
      if (idx == CFG_INNER_BLOCK_SIZE) begin
        inner_size = d[12:0];
      end else begin
        axis_len = d;
      end
    endfunction

    function bit at_tensor_head();
      return inner_pos == 0 && axis_pos == 0;
    endfunction

    // true if the next word would read a line store entry never written
    function bit reads_unwritten(logic ts);
      int unsigned ip;
      int unsigned ap;
      ip = ts ? 0 : inner_pos;
      ap = ts ? 0 : axis_pos;
      if (ip >= MaxInnerDef) ip = 0;
      return ap != 0 && !line_valid[ip];
    endfunction

    function void accumulate_word(logic signed [31:0] v, logic signed [31:0] p, logic ts);
      int unsigned isz;
      int unsigned alen;
      longint      total;
      logic        sat;
      isz  = (inner_size == 0) ? 1 : ((inner_size > MaxInnerDef) ? MaxInnerDef : inner_size);
      alen = (axis_len == 0) ? 1 : axis_len;
      if (ts) begin
        inner_pos = 0;
        axis_pos  = 0;
      end
      if (inner_pos >= MaxInnerDef) inner_pos = 0;
      total = longint'(v) + longint'(p);
      if (axis_pos != 0) total += longint'(line_mem[inner_pos]);
      sat = 1'b0;
      if (total > SumMax) begin
        total = SumMax;
        sat   = 1'b1;
      end else if (total < SumMin) begin
        total = SumMin;
        sat   = 1'b1;
      end
      line_mem[inner_pos]   = total[31:0];
      line_valid[inner_pos] = 1'b1;
      expected_sums.push_back(total[31:0]);
      expected_flags.push_back(sat);
      inner_pos++;
      if (inner_pos >= isz) begin
        inner_pos = 0;
        axis_pos++;
        if (axis_pos >= alen) axis_pos = 0;
      end
    endfunction

    function void check_sum_word(logic signed [31:0] s, logic sat);
      logic signed [31:0] exp_sum;
      logic               exp_sat;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result word sum %h saturated %b", $time, s, sat);
        errors++;
        return;
      end
      exp_sum = expected_sums.pop_front();
      exp_sat = expected_flags.pop_front();
      if (s !== exp_sum) begin
        $display("%0t: sum expected %h actual %h", $time, exp_sum, s);
        errors++;
      end
      if (sat !== exp_sat) begin
        $display("%0t: saturated expected %b actual %b", $time, exp_sat, sat);
        errors++;
      end
    endfunction

    function bit empty();
      return expected_sums.size() == 0;
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  cfg_idx_e           cfg_idx_i = CFG_INNER_BLOCK_SIZE;
  logic [15:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic signed [31:0] value_i = '0;
  logic signed [31:0] prior_i = '0;
  logic               tensor_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] sum_o;
  logic               saturated_o;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_from = 32'hFFFF_FFFF;

  cumsum_scoreboard sb = new();

  axis_cumulative_sum_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .value_i        (value_i),
    .prior_i        (prior_i),
    .tensor_start_i (tensor_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sum_o          (sum_o),
    .saturated_o    (saturated_o)
  );

  always #1 clk_i = ~clk_i;

  // receiver: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    out_stall_i <= (cycle_count >= hold_from && cycle_count - hold_from < HoldLen) ||
                   (stall_pct > 0 && $urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sum_word(sum_o, saturated_o);
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_word(logic signed [31:0] v, logic signed [31:0] p, logic ts);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    value_i        <= v;
    prior_i        <= p;
    tensor_start_i <= ts;
    do @(posedge clk_i); while (in_stall_o);
    sb.accumulate_word(v, p, ts);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (!sb.empty()) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [15:0] inner, logic [15:0] alen);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_INNER_BLOCK_SIZE;
    cfg_data_i <= inner;
    @(posedge clk_i);
    sb.write_reg(CFG_INNER_BLOCK_SIZE, inner);
    cfg_idx_i  <= CFG_AXIS_LENGTH;
    cfg_data_i <= alen;
    @(posedge clk_i);
    sb.write_reg(CFG_AXIS_LENGTH, alen);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_q16();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return r;
      5:       return {{9{r[22]}}, r[22:0]};
      default: return {{13{r[18]}}, r[18:0]};
    endcase
  endfunction

  // idle mode: 0 none, 1 sender, 2 receiver, 3 both
  task automatic run_phase(logic [15:0] inner, logic [15:0] alen, int words, int mode);
    logic               ts;
    logic               backward;
    logic signed [31:0] p;
    drain();
    write_config(inner, alen);
    idle_pct  = (mode == 1) ? 47 : (mode == 3) ? 34 : 0;
    stall_pct = (mode == 2) ? 47 : (mode == 3) ? 34 : 0;
    backward  = $urandom_range(1);
    repeat (words) begin
      if (sb.at_tensor_head()) ts = ($urandom_range(9) != 0);
      else ts = ($urandom_range(99) == 0);
      if (!ts && sb.reads_unwritten(1'b0)) ts = 1'b1;
      if (backward) p = rand_q16();
      else p = ($urandom_range(19) == 0) ? rand_q16() : '0;
      send_word(rand_q16(), p, ts);
    end
  endtask

  initial begin
    logic [15:0] inner;
    logic [15:0] alen;
    int          words;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // saturation both ways, wrap inside a three-term sum, restart mid tensor
    write_config(16'd2, 16'd3);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_word(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_word(32'h8000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0000_0001, 32'h0000_0000, 1'b0);
    send_word(32'h0001_0000, 32'h0000_0000, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h0002_8000, 1'b0);
    send_word(32'h0000_8000, 32'hFFFF_0000, 1'b0);
    send_word(32'h1234_5678, 32'h0000_0000, 1'b1);
    send_word(32'h0000_0010, 32'h0000_0000, 1'b0);
    send_word(32'h7FFF_0000, 32'h0000_FFFF, 1'b0);
    // zero sizes act as one
    drain();
    write_config(16'd0, 16'd0);
    send_word(32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
    send_word(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h0003_0000, 32'h0004_0000, 1'b0);
    // oversized inner size, longest axis
    drain();
    write_config(16'h1FFF, 16'hFFFF);
    send_word(32'h0001_0000, 32'h0000_0000, 1'b1);
    send_word(32'hFFFF_0000, 32'h0000_0000, 1'b0);
    // upper data bits beyond the inner register width are dropped
    drain();
    write_config(16'hE003, 16'd2);
    send_word(32'h0002_0000, 32'h0000_0000, 1'b1);
    send_word(32'h0003_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0004_0000, 32'h0000_0000, 1'b0);
    send_word(32'h0005_0000, 32'h0000_0000, 1'b0);

    for (int ph = 0; ph < 12; ph++) begin
      inner = $urandom_range(1, 12);
      alen  = $urandom_range(1, 10);
      words = 130;
      case (ph)
        3:       begin inner = 16'd4096; alen = 16'd2; end
        5:       begin inner = 16'd0;    alen = 16'd0; end
        7:       begin inner = 16'h1FFF; alen = 16'hFFFF; end
        9:       begin inner = 16'd1;    alen = 16'd1; end
        10:      begin inner = 16'd16;   alen = 16'hFFFF; end
        default: ;
      endcase
      run_phase(inner, alen, words, ph % 4);
    end

    // long receiver hold-off while the sender keeps offering
    drain();
    hold_from <= cycle_count + 5;
    run_phase(16'd5, 16'd7, 300, 0);

    drain();
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
